### rtl/core/lrt_pkg.sv
package lrt_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);

    typedef logic [IDX_W-1:0] t_idx;

    typedef enum logic [1:0] {
        OP_TOUCH   = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_RECLAIM = 2'd2,
        OP_FLUSH   = 2'd3
    } t_op;

    typedef struct packed {
        logic [ENTRIES-1:0]            listed;
        logic [ENTRIES-1:0][IDX_W-1:0] next_link;
        logic [ENTRIES-1:0][IDX_W-1:0] prev_link;
        logic [ENTRIES-1:0]            next_present;
        logic [ENTRIES-1:0]            prev_present;
        t_idx                          head;
        t_idx                          tail;
        logic                          nonempty;
    } t_lru_state;

    // unlink one slot, patching its neighbors and the head and tail
    function automatic t_lru_state f_unlink(t_lru_state s, t_idx e);
        t_lru_state r;
        t_idx       n;
        t_idx       p;
        r = s;
        n = s.next_link[e];
        p = s.prev_link[e];
        if (s.listed[e]) begin
            if (s.next_present[e]) begin
                r.prev_link[n]    = p;
                r.prev_present[n] = s.prev_present[e];
            end else if (s.prev_present[e]) begin
                r.tail = p;
            end
            if (s.prev_present[e]) begin
                r.next_link[p]    = n;
                r.next_present[p] = s.next_present[e];
            end else if (s.next_present[e]) begin
                r.head = n;
            end
            if (!s.next_present[e] && !s.prev_present[e]) begin
                r.nonempty = 1'b0;
                r.head     = '0;
                r.tail     = '0;
            end
            r.listed[e] = 1'b0;
        end
        return r;
    endfunction

    // move a slot to the head, inserting it if absent
    function automatic t_lru_state f_to_head(t_lru_state s, t_idx e);
        t_lru_state r;
        t_idx       h;
        r = s;
        if (!(s.listed[e] && !s.prev_present[e])) begin
            if (s.listed[e]) begin
                r = f_unlink(s, e);
            end
            h = r.head;
            r.listed[e] = 1'b1;
            if (r.nonempty) begin
                r.next_link[e]    = h;
                r.next_present[e] = 1'b1;
                r.prev_link[h]    = e;
                r.prev_present[h] = 1'b1;
            end else begin
                r.next_present[e] = 1'b0;
                r.tail            = e;
            end
            r.prev_present[e] = 1'b0;
            r.head            = e;
            r.nonempty        = 1'b1;
        end
        return r;
    endfunction

endpackage

### rtl/core/lru_replacement_tracker.sv
// LRU replacement tracker over a fixed set of slots, kept as a doubly
// linked list in per-slot registers (head = most recent, tail = least).
// Command channel: a word (i_operation, i_entry_index, i_requester_valid)
// is taken at a rising edge with start high and busy low. busy is always
// low: a new word can be taken in every cycle.
// Operations: touch moves a slot to the head, remove unlinks it, reclaim
// evicts the tail (a valid requester is held at the head meanwhile and
// dropped again if it was not listed), flush empties the list.
// Result channel: every word yields one result word (o_victim_found,
// o_victim_index), shown for exactly one cycle with o_done high. The
// receiver cannot stall; results come out in command order.
// Timing: the command is registered at the accepting edge, the list is
// updated and the result registered at the next edge, so o_done is high
// in the cycle after that. Throughput is one word per cycle, as the list
// update is done combinationally between the command and state registers.
// Reset (synchronous, active low on i_rst_n) empties the list and drops
// any word in flight; no result is produced for it.
module lru_replacement_tracker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_operation,
    input  logic [3:0] i_entry_index,
    input  logic       i_requester_valid,
    output logic       o_done,
    output logic       o_victim_found,
    output logic [3:0] o_victim_index
);

    logic               r_in_valid;
    lrt_pkg::t_op       r_op;
    lrt_pkg::t_idx      r_idx;
    logic               r_req;

    lrt_pkg::t_lru_state r_state;
    lrt_pkg::t_lru_state n_state;

    logic               r_done;
    logic               r_found;
    lrt_pkg::t_idx      r_victim;
    logic               n_found;
    lrt_pkg::t_idx      n_victim;

    lrt_pkg::t_lru_state s_req;
    lrt_pkg::t_lru_state s_evict;
    logic                was_listed;

    assign busy = 1'b0;

    always_comb begin
        n_state    = r_state;
        n_found    = 1'b0;
        n_victim   = '0;
        s_req      = r_state;
        s_evict    = r_state;
        was_listed = r_state.listed[r_idx];
        unique case (r_op)
            lrt_pkg::OP_TOUCH: begin
                n_state = lrt_pkg::f_to_head(r_state, r_idx);
            end
            lrt_pkg::OP_REMOVE: begin
                n_state = lrt_pkg::f_unlink(r_state, r_idx);
            end
            lrt_pkg::OP_RECLAIM: begin
                if (r_req) begin
                    s_req = lrt_pkg::f_to_head(r_state, r_idx);
                end
                s_evict = s_req;
                if (s_req.nonempty && (!r_req || (s_req.tail != r_idx))) begin
                    s_evict  = lrt_pkg::f_unlink(s_req, s_req.tail);
                    n_found  = 1'b1;
                    n_victim = s_req.tail;
                end
                n_state = s_evict;
                if (r_req && !was_listed) begin
                    n_state = lrt_pkg::f_unlink(s_evict, r_idx);
                end
            end
            lrt_pkg::OP_FLUSH: begin
                n_state.listed       = '0;
                n_state.next_present = '0;
                n_state.prev_present = '0;
                n_state.head         = '0;
                n_state.tail         = '0;
                n_state.nonempty     = 1'b0;
            end
            default: begin
                n_state = r_state;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid             <= 1'b0;
            r_done                 <= 1'b0;
            r_state.listed         <= '0;
            r_state.next_present   <= '0;
            r_state.prev_present   <= '0;
            r_state.head           <= '0;
            r_state.tail           <= '0;
            r_state.nonempty       <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
            r_done     <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op  <= lrt_pkg::t_op'(i_operation);
            r_idx <= i_entry_index;
            r_req <= i_requester_valid;
        end
        if (r_in_valid) begin
            r_found  <= n_found;
            r_victim <= n_victim;
        end
    end

    assign o_done         = r_done;
    assign o_victim_found = r_found;
    assign o_victim_index = r_victim;

endmodule
